[rtl/firlt_pkg.sv]
// Package for the loadable-tap FIR filter.
// Holds shared command/status types and fixed field widths; no dependencies.
package firlt_pkg;

    localparam int SMP_W  = 24;
    localparam int IDX_W  = 8;
    localparam int FRAC_W = 23;
    localparam int PROD_W = 2 * SMP_W;

    localparam logic [SMP_W-1:0] SMP_MAX = 24'h7F_FFFF;
    localparam logic [SMP_W-1:0] SMP_MIN = 24'h80_0000;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PUSH = 1'b1;

    typedef struct packed {
        logic load;
        logic push;
        logic issue;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
    } t_dp_sts;

endpackage

[rtl/firlt_if.sv]
// Valid/ready channel interfaces for the FIR filter: item input and result output.
// Depends on firlt_pkg for field widths.
interface firlt_in_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [firlt_pkg::IDX_W-1:0]        coef_index;
    logic signed [firlt_pkg::SMP_W-1:0] value;

    modport source (output valid, output action, output coef_index, output value,
                    input ready);
    modport sink   (input valid, input action, input coef_index, input value,
                    output ready);
endinterface

interface firlt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [firlt_pkg::SMP_W-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

[rtl/firlt_ctrl.sv]
// Controller for the FIR filter: sequences coefficient load, push, tap walk, drain and result transfer.
// Depends on firlt_pkg for command and status types.
module firlt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_action,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output firlt_pkg::t_dp_cmd o_cmd,
    input  firlt_pkg::t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   w_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign w_acc       = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.push  = 1'b0;
        o_cmd.issue = 1'b0;
        o_cmd.emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_in_action == firlt_pkg::ACT_PUSH) begin
                        o_cmd.push = 1'b1;
                        n_state    = S_RUN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

`ifndef SYNTHESIS
    a_last_tap_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && i_sts.last_tap) |=> (r_state == S_DRAIN))
        else $error("tap walk did not end in drain");

    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.pipe_busy)
        else $error("result taken before the accumulator settled");

    a_push_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> (r_state == S_RUN))
        else $error("sample push did not start the tap walk");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !o_cmd.emit)
        else $error("pending result overwritten");
`endif

endmodule

[rtl/firlt_dp.sv]
// Datapath for the FIR filter: sample and tap memories, shared MAC, saturation.
// Depends on firlt_pkg for command and status types and field widths.
module firlt_dp #(
    parameter int TAPS = 115
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  firlt_pkg::t_dp_cmd                 i_cmd,
    output firlt_pkg::t_dp_sts                 o_sts,
    input  logic [firlt_pkg::IDX_W-1:0]        i_coef_index,
    input  logic signed [firlt_pkg::SMP_W-1:0] i_value,
    output logic signed [firlt_pkg::SMP_W-1:0] o_filtered_sample
);

    localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W  = firlt_pkg::PROD_W + $clog2(TAPS);
    localparam int SHF_W  = ACC_W - firlt_pkg::FRAC_W;
    localparam int SW     = firlt_pkg::SMP_W;

    logic signed [SW-1:0] mem_smp  [TAPS];
    logic signed [SW-1:0] mem_coef [TAPS];
    logic [TAPS-1:0]      r_smp_vld;

    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_rptr;
    logic [AW-1:0]        r_tap;
    logic signed [SW-1:0] r_smp_q;
    logic signed [SW-1:0] r_coef_q;
    logic                 r_smp_ok;
    logic                 r_rd_vld;
    logic                 r_mul_vld;
    logic signed [firlt_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SW-1:0]    r_out;
    logic [SHF_W-1:0]        w_shf;
    logic [SW-1:0]           w_sat;
    logic                    w_idx_ok;
    logic signed [SW-1:0]    w_smp_op;

    assign n_head   = (r_head == AW'(TAPS - 1)) ? '0 : r_head + 1'b1;
    assign w_idx_ok = ({1'b0, i_coef_index} < (firlt_pkg::IDX_W + 1)'(TAPS));
    assign w_smp_op = r_smp_ok ? r_smp_q : '0;

    assign o_sts.last_tap  = (r_tap == AW'(TAPS - 1));
    assign o_sts.pipe_busy = r_rd_vld || r_mul_vld;
    assign o_filtered_sample = r_out;

    // Floor shift by the fraction width, then clamp to 24 bits
    assign w_shf = r_acc[ACC_W-1:firlt_pkg::FRAC_W];
    always_comb begin
        if (w_shf[SHF_W-1:SW-1] == {(SHF_W - SW + 1){w_shf[SW-1]}}) begin
            w_sat = w_shf[SW-1:0];
        end else if (w_shf[SHF_W-1]) begin
            w_sat = firlt_pkg::SMP_MIN;
        end else begin
            w_sat = firlt_pkg::SMP_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_idx_ok) begin
            mem_coef[i_coef_index[AW-1:0]] <= i_value;
        end
        if (i_cmd.issue) begin
            r_coef_q <= mem_coef[r_tap];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_smp[n_head] <= i_value;
        end
        if (i_cmd.issue) begin
            r_smp_q  <= mem_smp[r_rptr];
            r_smp_ok <= r_smp_vld[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_vld <= '0;
            r_head    <= '0;
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.issue;
            r_mul_vld <= r_rd_vld;
            if (i_cmd.push) begin
                r_smp_vld[n_head] <= 1'b1;
                r_head            <= n_head;
            end
        end
    end

    // Tap walk: newest sample first, stepping back round the ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_rptr <= n_head;
            r_tap  <= '0;
        end else if (i_cmd.issue) begin
            r_rptr <= (r_rptr == '0) ? AW'(TAPS - 1) : r_rptr - 1'b1;
            r_tap  <= r_tap + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_coef_q * w_smp_op;
        if (i_cmd.push) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.emit) begin
            r_out <= w_sat;
        end
    end

endmodule

[rtl/fir_filter_loadable_taps_unit.sv]
// Top level of the loadable-tap FIR filter: controller plus datapath.
// Depends on firlt_pkg, firlt_if, firlt_ctrl and firlt_dp.
//
//   port      dir  transfer moves
//   i_item    in   action, coef_index, value (coefficient load or sample push)
//   o_result  out  filtered_sample (one per sample push)
//
// A coefficient load is written straight into the tap table. A sample push
// walks the taps with one MAC step per tap, set by the single shared
// multiplier and the one read port of each memory, plus pipeline drain.
// Synchronous active-low reset clears the delay line at once through per-slot
// valid bits; the coefficient table is undefined until loaded.
// A pending result holds on o_result while loads and new sample pushes are still accepted.
module fir_filter_loadable_taps_unit #(
    parameter int TAPS = 115
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    firlt_in_if.sink             i_item,
    firlt_out_if.source          o_result
);

    firlt_pkg::t_dp_cmd w_cmd;
    firlt_pkg::t_dp_sts w_sts;

    firlt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_action (i_item.action),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    firlt_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_coef_index      (i_item.coef_index),
        .i_value           (i_item.value),
        .o_filtered_sample (o_result.filtered_sample)
    );

endmodule

[bench/fir_filter_loadable_taps_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for fir_filter_loadable_taps_unit: coefficient loads and sample pushes
// checked against an in-bench FIR predictor. Depends on firlt_pkg, firlt_if and the RTL.
module fir_filter_loadable_taps_unit_tb;

    localparam int TAPS        = 115;
    localparam int RAND_ITEMS  = 1600;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 2 * (TAPS + 5);
    localparam longint OUT_HI  = (longint'(1) <<< (firlt_pkg::SMP_W - 1)) - 1;
    localparam longint OUT_LO  = -(longint'(1) <<< (firlt_pkg::SMP_W - 1));

    typedef struct {
        logic                               action;
        logic [firlt_pkg::IDX_W-1:0]        coef_index;
        logic signed [firlt_pkg::SMP_W-1:0] value;
        bit                                 drain;
    } t_fir_item;

    logic i_clk;
    logic i_rst_n;

    firlt_in_if  item_if ();
    firlt_out_if result_if ();

    fir_filter_loadable_taps_unit #(.TAPS(TAPS)) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    t_fir_item                          item_backlog[$];
    logic signed [firlt_pkg::SMP_W-1:0] filtered_due[$];
    logic signed [firlt_pkg::SMP_W-1:0] tap_coef[TAPS];
    logic signed [firlt_pkg::SMP_W-1:0] sample_line[TAPS];

    int  total_items;
    int  accepted_count;
    int  n_loads;
    int  n_loads_ignored;
    int  n_pushes;
    int  n_checked;
    int  n_saturated;
    int  n_mismatch;
    int  n_errors;
    int  cycle_count;
    bit  in_took;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [firlt_pkg::SMP_W-1:0] filter_push(
        input logic signed [firlt_pkg::SMP_W-1:0] smp
    );
        longint acc;
        longint y;
        acc = 0;
        for (int k = TAPS - 1; k > 0; k--) begin
            sample_line[k] = sample_line[k-1];
        end
        sample_line[0] = smp;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(tap_coef[k]) * longint'(sample_line[k]);
        end
        y = acc >>> firlt_pkg::FRAC_W;
        if (y > OUT_HI) begin
            y = OUT_HI;
        end
        if (y < OUT_LO) begin
            y = OUT_LO;
        end
        return y[firlt_pkg::SMP_W-1:0];
    endfunction

    function automatic int idle_phase();
        if (accepted_count * 3 < total_items) begin
            return 0;
        end
        if (accepted_count * 3 < total_items * 2) begin
            return 1;
        end
        return 2;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic logic signed [firlt_pkg::SMP_W-1:0] rand_sample();
        case ($urandom_range(9, 0))
            0:       return firlt_pkg::SMP_MAX;
            1:       return firlt_pkg::SMP_MIN;
            default: return firlt_pkg::SMP_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [firlt_pkg::SMP_W-1:0] rand_coef();
        int r;
        r = $urandom_range(19, 0);
        case (r)
            0:       return firlt_pkg::SMP_MAX;
            1:       return firlt_pkg::SMP_MIN;
            2:       return '0;
            3, 4:    return firlt_pkg::SMP_W'($urandom());
            default: return firlt_pkg::SMP_W'($signed($urandom_range(2**18 - 1, 0)) - 2**17);
        endcase
    endfunction

    task automatic add_item(input logic act, input int idx,
                            input logic signed [firlt_pkg::SMP_W-1:0] val, input bit drain);
        t_fir_item it;
        it.action     = act;
        it.coef_index = idx[firlt_pkg::IDX_W-1:0];
        it.value      = val;
        it.drain      = drain;
        item_backlog.push_back(it);
    endtask

    // drive inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid   <= 1'b0;
            result_if.ready <= 1'b0;
        end else begin
            case (idle_phase())
                0:       result_if.ready <= !roll(51);
                1:       result_if.ready <= !roll(29);
                default: result_if.ready <= 1'b1;
            endcase
            if (!item_if.valid || in_took) begin
                if (item_backlog.size() == 0) begin
                    item_if.valid <= 1'b0;
                end else if (item_backlog[0].drain && filtered_due.size() != 0) begin
                    item_if.valid <= 1'b0;
                end else if ((idle_phase() == 0 && roll(29)) ||
                             (idle_phase() == 1 && roll(51))) begin
                    item_if.valid <= 1'b0;
                end else begin
                    item_if.valid      <= 1'b1;
                    item_if.action     <= item_backlog[0].action;
                    item_if.coef_index <= item_backlog[0].coef_index;
                    item_if.value      <= item_backlog[0].value;
                    void'(item_backlog.pop_front());
                end
            end
        end
    end

    // sample transfers on the rising edge
    always @(posedge i_clk) begin
        logic signed [firlt_pkg::SMP_W-1:0] want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= item_if.valid && item_if.ready;
            if (result_if.valid && result_if.ready) begin
                if (filtered_due.size() == 0) begin
                    n_errors++;
                    if (n_errors + n_mismatch <= 10) begin
                        $display("ERROR: unexpected output %0d", result_if.filtered_sample);
                    end
                end else begin
                    want = filtered_due.pop_front();
                    n_checked++;
                    if (want == firlt_pkg::SMP_MAX || want == firlt_pkg::SMP_MIN) begin
                        n_saturated++;
                    end
                    if (result_if.filtered_sample !== want) begin
                        n_mismatch++;
                        if (n_errors + n_mismatch <= 10) begin
                            $display("ERROR: output %0d: expected %0d, got %0d",
                                     n_checked, want, result_if.filtered_sample);
                        end
                    end
                end
            end
            if (item_if.valid && item_if.ready) begin
                accepted_count++;
                if (item_if.action == firlt_pkg::ACT_LOAD) begin
                    n_loads++;
                    if (item_if.coef_index < TAPS) begin
                        tap_coef[item_if.coef_index] = item_if.value;
                    end else begin
                        n_loads_ignored++;
                    end
                end else begin
                    n_pushes++;
                    filtered_due.push_back(filter_push(item_if.value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int r;
        i_rst_n            = 1'b0;
        item_if.valid      = 1'b0;
        item_if.action     = firlt_pkg::ACT_LOAD;
        item_if.coef_index = '0;
        item_if.value      = '0;
        result_if.ready    = 1'b0;
        cycle_count        = 0;
        for (int k = 0; k < TAPS; k++) begin
            tap_coef[k]    = '0;
            sample_line[k] = '0;
        end

        // fill every tap before the first push
        for (int k = 0; k < TAPS; k++) begin
            add_item(firlt_pkg::ACT_LOAD, k, (k == 0) ? firlt_pkg::SMP_MAX : '0, 0);
        end
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MAX, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_W'(-1), 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_W'(1), 0);
        add_item(firlt_pkg::ACT_LOAD, 0, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MAX, 0);
        add_item(firlt_pkg::ACT_LOAD, TAPS - 1, firlt_pkg::SMP_MAX, 0);
        add_item(firlt_pkg::ACT_LOAD, TAPS, 24'h12_3456, 0);
        add_item(firlt_pkg::ACT_LOAD, 255, firlt_pkg::SMP_MAX, 0);
        add_item(firlt_pkg::ACT_LOAD, 128, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_LOAD, 1, firlt_pkg::SMP_MAX, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_LOAD, 0, firlt_pkg::SMP_MAX, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, firlt_pkg::SMP_MIN, 0);
        add_item(firlt_pkg::ACT_PUSH, 0, '0, 0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            r = $urandom_range(99, 0);
            if (r < 55) begin
                add_item(firlt_pkg::ACT_PUSH, $urandom_range(255, 0), rand_sample(),
                         n % 400 == 0);
            end else if (r < 95) begin
                add_item(firlt_pkg::ACT_LOAD, $urandom_range(TAPS - 1, 0), rand_coef(),
                         n % 400 == 0);
            end else begin
                add_item(firlt_pkg::ACT_LOAD, $urandom_range(255, TAPS),
                         firlt_pkg::SMP_W'($urandom()), n % 400 == 0);
            end
        end
        total_items = item_backlog.size();

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (item_backlog.size() != 0 || item_if.valid) begin
            @(posedge i_clk);
        end
        while (filtered_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d coefficient loads (%0d outside the table) and %0d sample pushes;",
                 n_loads, n_loads_ignored, n_pushes);
        $display("checked %0d filter outputs, %0d of them clipped, in %0d cycles.",
                 n_checked, n_saturated, cycle_count);
        if (n_mismatch == 0 && n_errors == 0 && filtered_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[fir_filter_loadable_taps_unit.f]
rtl/firlt_pkg.sv
rtl/firlt_if.sv
rtl/firlt_ctrl.sv
rtl/firlt_dp.sv
rtl/fir_filter_loadable_taps_unit.sv
bench/fir_filter_loadable_taps_unit_tb.sv
